@@ rtl/dqs_pkg.sv @@
// ---------------------------------------------------------------------------
// dqs_pkg
// Shared types and codes for the double-ended queue with search.
// ---------------------------------------------------------------------------
package dqs_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 7;

    // request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN
    } t_state;

endpackage

@@ rtl/deque_with_search_core.sv @@
// ---------------------------------------------------------------------------
// deque_with_search_core
// Bounded double-ended queue of signed words kept as a ring buffer in one
// synchronous memory, with push/pop at both ends and a linear value search.
// ---------------------------------------------------------------------------
// Push, refused push, empty pop/search and unused codes give their result in
//   the cycle after accept, with busy staying low (one per cycle).
// Pop: the memory read is registered, then the result is registered; busy for 1 cycle.
// Search: one memory read per stored word, stopping at the first match; the
//   result comes when a word matches or the last stored word has been compared.
// The single read port of the entry memory sets the search rate.
// Reset (synchronous, active low) empties the queue; the memory is not cleared.
// Results are strobed for one cycle by o_valid; the receiver cannot stall.
// ---------------------------------------------------------------------------
module deque_with_search_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dqs_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [dqs_pkg::WORD_W-1:0]   i_item_value,
    output logic                                o_valid,
    output logic [dqs_pkg::STAT_W-1:0]          o_status,
    output logic signed [dqs_pkg::WORD_W-1:0]   o_removed_value,
    output logic                                o_found,
    output logic [dqs_pkg::OCC_W-1:0]           o_occupancy
);

    // pointer width, count width (count must hold DEPTH itself), sum width
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    // Wrap base + offset into the ring; both stay below DEPTH, so one
    // compare and subtract is enough.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // entry memory: one write and one registered read per cycle
    logic [dqs_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [dqs_pkg::WORD_W-1:0] r_rdata;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [AW-1:0]              mem_raddr;

    // control state
    dqs_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic            r_valid, n_valid;
    logic            r_rd_v, n_rd_v;       // read issued last cycle during scan

    // payload state
    logic [dqs_pkg::STAT_W-1:0] r_status, n_status;
    logic [dqs_pkg::WORD_W-1:0] r_removed, n_removed;
    logic                       r_found, n_found;
    logic [dqs_pkg::WORD_W-1:0] r_key, n_key;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_rd_last, n_rd_last;

    logic           accept;
    logic           is_full;
    logic           is_empty;
    logic [CW+dqs_pkg::OCC_W-1:0] occ_wide;

    assign busy     = (r_state != dqs_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Sequencer: updates pointers at accept, issues memory reads and
    // builds the result.
    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_rd_v    = 1'b0;
        n_status  = r_status;
        n_removed = r_removed;
        n_found   = r_found;
        n_key     = r_key;
        n_idx     = r_idx;
        n_rd_last = r_rd_last;
        mem_we    = 1'b0;
        mem_waddr = r_front;
        mem_raddr = r_front;

        case (r_state)
            dqs_pkg::ST_IDLE: begin
                if (accept) begin
                    // default result: ok, nothing removed, nothing found
                    n_status  = dqs_pkg::STAT_OK;
                    n_removed = '0;
                    n_found   = 1'b0;
                    case (i_mode)
                        dqs_pkg::MODE_PUSH_FRONT: begin
                            n_valid = 1'b1;
                            if (is_full) begin
                                n_status = dqs_pkg::STAT_FULL;
                            end else begin
                                n_front   = (r_front == '0) ? AW'(DEPTH - 1)
                                                            : r_front - AW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = n_front;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        dqs_pkg::MODE_PUSH_REAR: begin
                            n_valid = 1'b1;
                            if (is_full) begin
                                n_status = dqs_pkg::STAT_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = ring_add(r_front, r_count);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        dqs_pkg::MODE_POP_FRONT: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = dqs_pkg::STAT_EMPTY;
                            end else begin
                                mem_raddr = r_front;
                                n_front   = ring_add(r_front, CW'(1));
                                n_count   = r_count - CW'(1);
                                n_state   = dqs_pkg::ST_POP;
                            end
                        end
                        dqs_pkg::MODE_POP_REAR: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = dqs_pkg::STAT_EMPTY;
                            end else begin
                                mem_raddr = ring_add(r_front, r_count - CW'(1));
                                n_count   = r_count - CW'(1);
                                n_state   = dqs_pkg::ST_POP;
                            end
                        end
                        dqs_pkg::MODE_SEARCH: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = dqs_pkg::STAT_EMPTY;
                            end else begin
                                n_key   = i_item_value;
                                n_idx   = '0;
                                n_state = dqs_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            // unused code: no operation, plain ok result
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            dqs_pkg::ST_POP: begin
                // read data is back; deliver it
                n_valid   = 1'b1;
                n_removed = r_rdata;
                n_state   = dqs_pkg::ST_IDLE;
            end
            dqs_pkg::ST_SCAN: begin
                mem_raddr = ring_add(r_front, r_idx);
                if (r_rd_v && (r_rdata == r_key)) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_state = dqs_pkg::ST_IDLE;
                end else if (r_rd_v && r_rd_last) begin
                    n_valid = 1'b1;
                    n_state = dqs_pkg::ST_IDLE;
                end else begin
                    // issue next read, compare it next cycle
                    n_rd_v    = 1'b1;
                    n_rd_last = (r_idx == r_count - CW'(1));
                    n_idx     = r_idx + CW'(1);
                end
            end
            default: begin
                n_state = dqs_pkg::ST_IDLE;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_item_value;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqs_pkg::ST_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_valid <= n_valid;
            r_rd_v  <= n_rd_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_rd_last <= n_rd_last;
    end

    // occupancy is the count masked to the port width
    assign occ_wide = {{dqs_pkg::OCC_W{1'b0}}, r_count};

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_found         = r_found;
    assign o_occupancy     = occ_wide[dqs_pkg::OCC_W-1:0];

endmodule

@@ rtl/dqs_checker.sv @@
// ---------------------------------------------------------------------------
// dqs_checker
// Port-level checks for the double-ended queue with search, bound to the top.
// ---------------------------------------------------------------------------
module dqs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [dqs_pkg::MODE_W-1:0]         i_mode,
    input logic                               o_valid,
    input logic [dqs_pkg::STAT_W-1:0]         o_status,
    input logic signed [dqs_pkg::WORD_W-1:0]  o_removed_value,
    input logic                               o_found,
    input logic [dqs_pkg::OCC_W-1:0]          o_occupancy
);

    logic push_acc;
    assign push_acc = start && !busy &&
                      ((i_mode == dqs_pkg::MODE_PUSH_FRONT) ||
                       (i_mode == dqs_pkg::MODE_PUSH_REAR));

    // a push transaction always answers in the next cycle
    a_push_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_acc |=> o_valid)
        else $error("push transaction gave no result in the next cycle");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == dqs_pkg::STAT_OK) ||
                    (o_status == dqs_pkg::STAT_EMPTY) ||
                    (o_status == dqs_pkg::STAT_FULL))
        else $error("illegal status code");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == dqs_pkg::STAT_EMPTY)) |-> (o_occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != dqs_pkg::STAT_OK)) |->
            ((o_removed_value == '0) && !o_found))
        else $error("failed transaction carries data or found flag");

    // no result while a search is still in progress
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> !o_valid)
        else $error("result strobed during a multi-cycle transaction");

endmodule

bind deque_with_search_core dqs_checker u_dqs_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for deque_with_search_core: a directed table covering
// empty corners, extreme words and unused codes, followed by fill, drain
// and mixed episodes of random requests. Each transaction runs through an
// in-bench mirror of the ring buffer, and every result strobe is compared
// field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module tb;

    localparam int unsigned DEPTH        = 64;
    localparam int unsigned PTR_W        = $clog2(DEPTH);
    localparam int unsigned RANDOM_ITEMS = 1050;
    // Longest quiet stretch of a good run is a full-depth search plus a
    // sender gap; allow many times that before calling it a hang.
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned TAIL_CYCLES  = DEPTH + 4;

    typedef logic [dqs_pkg::MODE_W-1:0]        t_mode;
    typedef logic signed [dqs_pkg::WORD_W-1:0] t_word;
    typedef logic [dqs_pkg::WORD_W-1:0]        t_field;
    typedef logic [dqs_pkg::STAT_W-1:0]        t_status;
    typedef logic [dqs_pkg::OCC_W-1:0]         t_occ;

    // Codes outside the request set: the block must treat them as no-ops.
    localparam t_mode MODE_NOP_5 = 3'd5;
    localparam t_mode MODE_NOP_6 = 3'd6;
    localparam t_mode MODE_NOP_7 = 3'd7;

    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_status status;
        t_word   removed;
        logic    found;
        t_occ    occupancy;
    } t_outcome;

    typedef struct {
        t_mode    mode;
        t_word    value;
        bit       pinned;
        t_outcome want;
    } t_request_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_mode   i_mode;
    t_word   i_item_value;
    logic    o_valid;
    t_status o_status;
    t_word   o_removed_value;
    logic    o_found;
    t_occ    o_occupancy;

    deque_with_search_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_item_value   (i_item_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_found        (o_found),
        .o_occupancy    (o_occupancy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the ring buffer, advanced once per accepted transaction.
    t_word            mirror_store [DEPTH];
    logic [PTR_W-1:0] mirror_front;
    t_occ             mirror_count;

    t_outcome     pending_results [$];
    t_request_row directed_rows [$];

    // Pinned expectation travels with the request it belongs to.
    bit       pin_now;
    t_outcome pin_want;

    int unsigned failures;
    int unsigned quiet_cycles;
    int unsigned n_push, n_push_full, n_pop, n_pop_empty;
    int unsigned n_search, n_search_hit, n_nop, peak_occupancy;

    t_outcome predicted;

    // Apply one request to the mirror and return the result it must produce.
    function automatic t_outcome apply_request(input t_mode mode, input t_word value);
        t_outcome         res;
        logic [PTR_W-1:0] slot;
        res = '0;
        case (mode)
            dqs_pkg::MODE_PUSH_FRONT: begin
                if (mirror_count >= t_occ'(DEPTH)) begin
                    res.status = dqs_pkg::STAT_FULL;
                end else begin
                    mirror_front               = mirror_front - PTR_W'(1);
                    mirror_store[mirror_front] = value;
                    mirror_count               = mirror_count + t_occ'(1);
                end
            end
            dqs_pkg::MODE_PUSH_REAR: begin
                if (mirror_count >= t_occ'(DEPTH)) begin
                    res.status = dqs_pkg::STAT_FULL;
                end else begin
                    slot               = mirror_front + mirror_count[PTR_W-1:0];
                    mirror_store[slot] = value;
                    mirror_count       = mirror_count + t_occ'(1);
                end
            end
            dqs_pkg::MODE_POP_FRONT: begin
                if (mirror_count == '0) begin
                    res.status = dqs_pkg::STAT_EMPTY;
                end else begin
                    res.removed  = mirror_store[mirror_front];
                    mirror_front = mirror_front + PTR_W'(1);
                    mirror_count = mirror_count - t_occ'(1);
                end
            end
            dqs_pkg::MODE_POP_REAR: begin
                if (mirror_count == '0) begin
                    res.status = dqs_pkg::STAT_EMPTY;
                end else begin
                    slot         = mirror_front + mirror_count[PTR_W-1:0] - PTR_W'(1);
                    res.removed  = mirror_store[slot];
                    mirror_count = mirror_count - t_occ'(1);
                end
            end
            dqs_pkg::MODE_SEARCH: begin
                if (mirror_count == '0) begin
                    res.status = dqs_pkg::STAT_EMPTY;
                end else begin
                    for (int k = 0; k < int'(mirror_count); k++) begin
                        slot = mirror_front + PTR_W'(k);
                        if (mirror_store[slot] == value) begin
                            res.found = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // unused code: nothing moves
            end
        endcase
        res.occupancy = mirror_count;
        return res;
    endfunction

    task automatic check_field(input string name, input t_field want, input t_field got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // Monitor: check the strobed result first (it belongs to an older
    // transaction), then predict the one accepted at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    failures++;
                end else begin
                    predicted = pending_results.pop_front();
                    check_field("status", t_field'(predicted.status), t_field'(o_status));
                    check_field("removed_value", predicted.removed, o_removed_value);
                    check_field("found", t_field'(predicted.found), t_field'(o_found));
                    check_field("occupancy", t_field'(predicted.occupancy),
                                t_field'(o_occupancy));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                predicted = apply_request(i_mode, i_item_value);
                case (i_mode)
                    dqs_pkg::MODE_PUSH_FRONT, dqs_pkg::MODE_PUSH_REAR: begin
                        n_push++;
                        if (predicted.status == dqs_pkg::STAT_FULL) n_push_full++;
                    end
                    dqs_pkg::MODE_POP_FRONT, dqs_pkg::MODE_POP_REAR: begin
                        n_pop++;
                        if (predicted.status == dqs_pkg::STAT_EMPTY) n_pop_empty++;
                    end
                    dqs_pkg::MODE_SEARCH: begin
                        n_search++;
                        if (predicted.found) n_search_hit++;
                    end
                    default: n_nop++;
                endcase
                if (32'(predicted.occupancy) > peak_occupancy) begin
                    peak_occupancy = 32'(predicted.occupancy);
                end
                pending_results.push_back(pin_now ? pin_want : predicted);
            end
            if (o_valid === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic add_row(input t_mode mode, input t_word value, input int pinned,
                           input t_status status, input t_word removed,
                           input int found, input int occupancy);
        t_request_row row;
        row.mode           = mode;
        row.value          = value;
        row.pinned         = (pinned != 0);
        row.want.status    = status;
        row.want.removed   = removed;
        row.want.found     = (found != 0);
        row.want.occupancy = t_occ'(occupancy);
        directed_rows.push_back(row);
    endtask

    // Present one transaction at the falling edge and hold it until accepted.
    task automatic send_request(input t_mode mode, input t_word value,
                                input bit pinned, input t_outcome want);
        @(negedge i_clk);
        start        <= 1'b1;
        i_mode       <= mode;
        i_item_value <= value;
        pin_now      <= pinned;
        pin_want     <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_cycles(input int unsigned n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_word random_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Draw one request; push_pct biases the episode toward filling or draining.
    task automatic pick_request(input int unsigned push_pct,
                                output t_mode mode, output t_word value);
        int unsigned      roll;
        logic [PTR_W-1:0] slot;
        roll  = $urandom_range(0, 99);
        value = random_word();
        if (roll < 4) begin
            case ($urandom_range(0, 2))
                0:       mode = MODE_NOP_5;
                1:       mode = MODE_NOP_6;
                default: mode = MODE_NOP_7;
            endcase
        end else if (roll < 19) begin
            mode = dqs_pkg::MODE_SEARCH;
            // half the searches on a non-empty store look for a word that is actually stored
            if (mirror_count != '0 && $urandom_range(0, 1) != 0) begin
                slot  = mirror_front + PTR_W'($urandom_range(0, int'(mirror_count) - 1));
                value = mirror_store[slot];
            end
        end else if ($urandom_range(0, 99) < push_pct) begin
            mode = ($urandom_range(0, 1) != 0) ? dqs_pkg::MODE_PUSH_REAR
                                               : dqs_pkg::MODE_PUSH_FRONT;
        end else begin
            mode = ($urandom_range(0, 1) != 0) ? dqs_pkg::MODE_POP_REAR
                                               : dqs_pkg::MODE_POP_FRONT;
        end
    endtask

    initial begin
        t_mode       mode;
        t_word       value;
        int unsigned issued;
        int unsigned episode;
        int unsigned ep_len;
        int unsigned push_pct;
        int unsigned burst_left;
        t_outcome    none;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = dqs_pkg::MODE_PUSH_FRONT;
        i_item_value   = '0;
        pin_now        = 1'b0;
        pin_want       = '0;
        none           = '0;
        mirror_front   = '0;
        mirror_count   = '0;
        failures       = 0;
        quiet_cycles   = 0;
        n_push         = 0;
        n_push_full    = 0;
        n_pop          = 0;
        n_pop_empty    = 0;
        n_search       = 0;
        n_search_hit   = 0;
        n_nop          = 0;
        peak_occupancy = 0;
        for (int k = 0; k < DEPTH; k++) mirror_store[k] = '0;

        // Directed table: empty-store requests, unused codes, extreme words at
        // both ends, searches that hit and miss, then drain back to empty.
        add_row(dqs_pkg::MODE_POP_FRONT,  '0,             1, dqs_pkg::STAT_EMPTY, '0,       0, 0);
        add_row(dqs_pkg::MODE_POP_REAR,   32'sh5A5A_5A5A, 1, dqs_pkg::STAT_EMPTY, '0,       0, 0);
        add_row(dqs_pkg::MODE_SEARCH,     '0,             1, dqs_pkg::STAT_EMPTY, '0,       0, 0);
        add_row(MODE_NOP_5,               -32'sd1,        1, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(MODE_NOP_6,               WORD_MAX,       1, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(MODE_NOP_7,               WORD_MIN,       1, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(dqs_pkg::MODE_PUSH_FRONT, WORD_MAX,       1, dqs_pkg::STAT_OK,    '0,       0, 1);
        add_row(dqs_pkg::MODE_PUSH_REAR,  WORD_MIN,       1, dqs_pkg::STAT_OK,    '0,       0, 2);
        add_row(dqs_pkg::MODE_PUSH_FRONT, '0,             1, dqs_pkg::STAT_OK,    '0,       0, 3);
        add_row(dqs_pkg::MODE_PUSH_REAR,  -32'sd1,        1, dqs_pkg::STAT_OK,    '0,       0, 4);
        add_row(dqs_pkg::MODE_SEARCH,     WORD_MIN,       0, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(dqs_pkg::MODE_SEARCH,     32'sd1,         0, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(dqs_pkg::MODE_SEARCH,     -32'sd1,        0, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(MODE_NOP_5,               '0,             1, dqs_pkg::STAT_OK,    '0,       0, 4);
        add_row(dqs_pkg::MODE_POP_FRONT,  32'sd99,        0, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(dqs_pkg::MODE_POP_REAR,   '0,             0, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(dqs_pkg::MODE_POP_FRONT,  '0,             1, dqs_pkg::STAT_OK,    WORD_MAX, 0, 1);
        add_row(dqs_pkg::MODE_POP_REAR,   '0,             1, dqs_pkg::STAT_OK,    WORD_MIN, 0, 0);
        add_row(dqs_pkg::MODE_POP_REAR,   '0,             1, dqs_pkg::STAT_EMPTY, '0,       0, 0);
        add_row(dqs_pkg::MODE_SEARCH,     WORD_MAX,       1, dqs_pkg::STAT_EMPTY, '0,       0, 0);
        add_row(dqs_pkg::MODE_PUSH_REAR,  32'sh1234_5678, 0, dqs_pkg::STAT_OK,    '0,       0, 0);
        add_row(dqs_pkg::MODE_POP_FRONT,  '0,             0, dqs_pkg::STAT_OK,    '0,       0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].mode, directed_rows[r].value,
                         directed_rows[r].pinned, directed_rows[r].want);
        end

        // Let the directed part settle completely before the random episodes.
        wait_drained();

        // Random episodes: the first fills past full, later ones lean toward
        // filling, draining or a balanced mix. Unused codes ride along as noise.
        issued     = 0;
        episode    = 0;
        burst_left = $urandom_range(1, 24);
        while (issued < RANDOM_ITEMS) begin
            if (episode == 0) begin
                push_pct = 100;
                ep_len   = 100;
            end else begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
                ep_len = $urandom_range(30, 160);
            end
            for (int i = 0; i < ep_len && issued < RANDOM_ITEMS; i++) begin
                pick_request(push_pct, mode, value);
                send_request(mode, value, 1'b0, none);
                if (mode <= dqs_pkg::MODE_SEARCH) issued++;
                burst_left--;
                if (burst_left == 0) begin
                    // a quarter of the bursts run straight into the next one
                    if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 24);
                end
                if ($urandom_range(0, 199) == 0) wait_drained();
            end
            episode++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end
        $display("Covered %0d pushes (%0d refused full), %0d pops (%0d on empty),",
                 n_push, n_push_full, n_pop, n_pop_empty);
        $display("  %0d searches (%0d hits), %0d unused codes, peak occupancy %0d of %0d",
                 n_search, n_search_hit, n_nop, peak_occupancy, DEPTH);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
